FILE: rtl/single_source_shortest_paths_assert.svh
// assertion macros shared by the shortest path block
`ifndef SINGLE_SOURCE_SHORTEST_PATHS_ASSERT_SVH
`define SINGLE_SOURCE_SHORTEST_PATHS_ASSERT_SVH

// same-cycle implication, muted during reset
`define SSSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, muted during reset
`define SSSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sssp_pkg.sv
// constants, register indexes and state codes for the shortest path block
package sssp_pkg;

  localparam int NODE_W = 6;
  localparam int COST_W = 16;
  localparam int DIST_W = 32;
  localparam int CNT_W  = 7;
  localparam int EDGE_W = 2 * NODE_W + COST_W;

  localparam int DEF_MAX_NODES = 64;
  localparam int DEF_MAX_EDGES = 1024;

  localparam logic [CNT_W-1:0]  NODE_COUNT_RST = 7'd64;
  localparam logic [NODE_W-1:0] START_NODE_RST = 6'd0;

  // configuration register indexes
  localparam logic [0:0] REG_NODE_COUNT = 1'b0;
  localparam logic [0:0] REG_START_NODE = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_INIT     = 7'b0000010,
    S_FETCH    = 7'b0000100,
    S_READ     = 7'b0001000,
    S_RELAX    = 7'b0010000,
    S_OUT_RD   = 7'b0100000,
    S_OUT_SEND = 7'b1000000
  } state_t;

endpackage

FILE: rtl/single_source_shortest_paths.sv
// single-source shortest paths over a loaded edge list, one shared relax unit
//
// Edges stream in one per cycle and are appended to the edge store; the edge
// with tlast set starts a run and input stalls until every node result has been
// taken. A run starts with a setup step, then makes up to node_count passes over
// the stored edges, since a single relax unit handles one edge at a time through
// the edge store read, the two-port distance read and the compare-and-write.
// Each node result is read from the distance store, then sent and held while
// the output stalls. Passes stop early once one pass changes nothing; if pass
// node_count still changed a distance, every result of the run carries the
// negative-cycle flag. Distances saturate to the 32-bit signed range, edges
// with an endpoint at or above node_count are skipped, edges past the store
// depth are dropped, and the store is empty again after the last result.
module single_source_shortest_paths
  import sssp_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_EDGES = DEF_MAX_EDGES
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  // edge input: edge_from[5:0], edge_to[11:6], edge_cost[27:12], zero fill
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        s_tlast,
  // node result: node_id[5:0], path_length[37:6], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  // node flags: reachable[0], negative_cycle[1]
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1) > 0 ? $clog2(MAX_EDGES + 1) : 1;
  localparam logic [CNT_W-1:0] MAXN = CNT_W'(MAX_NODES);
  localparam logic [CW-1:0]    MAXE = CW'(MAX_EDGES);

  state_t state, state_next;

  logic [CNT_W-1:0]  node_count;
  logic [NODE_W-1:0] start_node;
  logic [CNT_W-1:0]  n_eff;

  logic [EDGE_W-1:0] edge_mem [MAX_EDGES];
  logic [DIST_W-1:0] dist_mem [MAX_NODES];
  logic              vld [MAX_NODES];

  logic [CW-1:0]     edge_total;
  logic [CW-1:0]     edge_idx;
  logic [EDGE_W-1:0] edge_rd;
  logic [DIST_W-1:0] du, dv, dout;
  logic              changed;
  logic [CNT_W-1:0]  pass_cnt;
  logic [CNT_W-1:0]  pass_next;
  logic [CNT_W-1:0]  k;

  logic                     s_acc, m_acc;
  logic                     start_ok;
  logic [NODE_W-1:0]        eu, ev;
  logic signed [COST_W-1:0] ecost;
  logic signed [DIST_W:0]   sum;
  logic signed [DIST_W-1:0] cand;
  logic                     skip, upd;
  logic                     pass_end, more_pass;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign m_acc     = m_tvalid && m_tready;

  always_comb begin
    if (node_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (node_count > MAXN) begin
      n_eff = MAXN;
    end else begin
      n_eff = node_count;
    end
  end

  assign start_ok = ({1'b0, start_node} < n_eff);

  // relax unit: saturated candidate and the update decision
  // stored edge layout matches the input transaction: from, to, cost from bit 0 up
  assign eu    = edge_rd[NODE_W-1:0];
  assign ev    = edge_rd[NODE_W +: NODE_W];
  assign ecost = edge_rd[2*NODE_W +: COST_W];
  assign sum   = {du[DIST_W-1], du} + (DIST_W+1)'(ecost);

  always_comb begin
    if (sum[DIST_W] != sum[DIST_W-1]) begin
      cand = sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
    end else begin
      cand = sum[DIST_W-1:0];
    end
  end

  assign skip = ({1'b0, eu} >= n_eff) || ({1'b0, ev} >= n_eff) || !vld[eu[NW-1:0]];
  assign upd  = !skip && (!vld[ev[NW-1:0]] || (cand < $signed(dv)));

  assign pass_end  = (edge_idx == edge_total);
  assign pass_next = pass_cnt + CNT_W'(1);
  assign more_pass = changed && (pass_next < n_eff);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (s_acc && s_tlast) state_next = S_INIT;
      S_INIT:     state_next = start_ok ? S_FETCH : S_OUT_RD;
      S_FETCH:    if (!pass_end) begin
                    state_next = S_READ;
                  end else if (!more_pass) begin
                    state_next = S_OUT_RD;
                  end
      S_READ:     state_next = S_RELAX;
      S_RELAX:    state_next = S_FETCH;
      S_OUT_RD:   state_next = S_OUT_SEND;
      S_OUT_SEND: if (m_tready) state_next = (k == n_eff - CNT_W'(1)) ? S_IDLE : S_OUT_RD;
      default:    state_next = S_IDLE;
    endcase
  end

  // memories: edge store and distance values
  always_ff @(posedge clk) begin
    if (s_acc && (edge_total < MAXE)) begin
      edge_mem[edge_total[EW-1:0]] <= s_tdata[EDGE_W-1:0];
    end
    if (state == S_FETCH) begin
      edge_rd <= edge_mem[edge_idx[EW-1:0]];
    end
    if (state == S_INIT) begin
      dist_mem[start_node[NW-1:0]] <= '0;
    end else if ((state == S_RELAX) && upd) begin
      dist_mem[ev[NW-1:0]] <= cand;
    end
    if (state == S_READ) begin
      du <= dist_mem[eu[NW-1:0]];
      dv <= dist_mem[ev[NW-1:0]];
    end
    if (state == S_OUT_RD) begin
      dout <= dist_mem[k[NW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= NODE_COUNT_RST;
      start_node <= START_NODE_RST;
      edge_total <= '0;
      edge_idx   <= '0;
      changed    <= 1'b0;
      pass_cnt   <= '0;
      k          <= '0;
      for (int i = 0; i < MAX_NODES; i++) vld[i] <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NODE_COUNT: node_count <= cfg_data;
          REG_START_NODE: start_node <= cfg_data[NODE_W-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (s_acc && (edge_total < MAXE)) edge_total <= edge_total + CW'(1);
        end
        S_INIT: begin
          for (int i = 0; i < MAX_NODES; i++) vld[i] <= 1'b0;
          if (start_ok) vld[start_node[NW-1:0]] <= 1'b1;
          changed  <= 1'b0;
          pass_cnt <= '0;
          edge_idx <= '0;
          k        <= '0;
        end
        S_FETCH: begin
          if (pass_end) begin
            pass_cnt <= pass_next;
            if (more_pass) begin
              changed  <= 1'b0;
              edge_idx <= '0;
            end
          end
        end
        S_RELAX: begin
          edge_idx <= edge_idx + CW'(1);
          if (upd) begin
            vld[ev[NW-1:0]] <= 1'b1;
            changed         <= 1'b1;
          end
        end
        S_OUT_SEND: begin
          if (m_tready) begin
            k <= k + CNT_W'(1);
            if (k == n_eff - CNT_W'(1)) edge_total <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tvalid = (state == S_OUT_SEND);
  assign m_tdata  = {2'b00, (vld[k[NW-1:0]] ? dout : {DIST_W{1'b0}}), k[NODE_W-1:0]};
  assign m_tuser  = {changed, vld[k[NW-1:0]]};
  assign m_tlast  = (k == n_eff - CNT_W'(1));

`include "single_source_shortest_paths_assert.svh"

  `SSSP_ASSERT_NOW(a_no_load_during_results, m_tvalid, !s_tready, "edge taken while results pending")
  `SSSP_ASSERT_NEXT(a_store_empty_after_run, m_acc && m_tlast, edge_total == '0, "edge store not emptied")
  `SSSP_ASSERT_NOW(a_pass_bound, m_tvalid, pass_cnt <= n_eff, "pass count beyond node count")
  `SSSP_ASSERT_NOW(a_start_reachable, m_tvalid && start_ok && (k[NODE_W-1:0] == start_node), m_tuser[0], "start node reported unreachable")

endmodule

FILE: tb/sv/single_source_shortest_paths_test.sv
// self-checking testbench for the single-source shortest path block
`timescale 1ns / 1ps

module single_source_shortest_paths_test;
  import sssp_pkg::*;

  localparam int MAX_NODES     = DEF_MAX_NODES;
  localparam int MAX_EDGES     = DEF_MAX_EDGES;
  localparam int QUIET_LIMIT   = 40000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS  = 190;
  localparam longint DIST_MAX  = 64'sd2147483647;
  localparam longint DIST_MIN  = -64'sd2147483648;

  typedef struct packed {
    logic [NODE_W-1:0]        node;
    logic signed [DIST_W-1:0] length;
    logic                     reach;
    logic                     neg_cycle;
    logic                     last;
  } node_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = REG_NODE_COUNT;
  logic [6:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  // predictor copy of the block state
  logic [NODE_W-1:0]        stored_from [MAX_EDGES];
  logic [NODE_W-1:0]        stored_to [MAX_EDGES];
  logic signed [COST_W-1:0] stored_cost [MAX_EDGES];
  int                       stored_count = 0;
  logic [CNT_W-1:0]         node_count_reg = NODE_COUNT_RST;
  logic [NODE_W-1:0]        start_node_reg = START_NODE_RST;

  node_result_t expected_nodes[$];
  int mismatch_count = 0;
  int tx_max_gap = 8;
  int rx_max_gap = 8;
  int rx_hold_request = 0;
  int quiet_cycles = 0;

  single_source_shortest_paths uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    mismatch_count++;
  endtask

  // store one edge; the final edge runs the relaxation and queues one result per node
  task automatic predict_edge(input logic [NODE_W-1:0] from, input logic [NODE_W-1:0] to,
                              input logic signed [COST_W-1:0] cost, input logic fin);
    int n;
    int pass_no;
    int u;
    int v;
    bit changed;
    longint cand;
    longint path_est [MAX_NODES];
    bit known [MAX_NODES];
    node_result_t res;
    if (stored_count < MAX_EDGES) begin
      stored_from[stored_count] = from;
      stored_to[stored_count] = to;
      stored_cost[stored_count] = cost;
      stored_count++;
    end
    if (!fin) return;
    n = node_count_reg;
    if (n < 1) n = 1;
    if (n > MAX_NODES) n = MAX_NODES;
    foreach (known[k]) begin
      known[k] = 1'b0;
      path_est[k] = 0;
    end
    changed = 1'b0;
    if (start_node_reg < n) begin
      known[start_node_reg] = 1'b1;
      pass_no = 0;
      do begin
        changed = 1'b0;
        for (int i = 0; i < stored_count; i++) begin
          u = stored_from[i];
          v = stored_to[i];
          if (u < n && v < n && known[u]) begin
            cand = path_est[u] + longint'(stored_cost[i]);
            if (cand > DIST_MAX) cand = DIST_MAX;
            if (cand < DIST_MIN) cand = DIST_MIN;
            if (!known[v] || cand < path_est[v]) begin
              known[v] = 1'b1;
              path_est[v] = cand;
              changed = 1'b1;
            end
          end
        end
        pass_no++;
      end while (changed && pass_no < n);
    end
    for (int k = 0; k < n; k++) begin
      res.node = k[NODE_W-1:0];
      res.length = known[k] ? path_est[k][DIST_W-1:0] : '0;
      res.reach = known[k];
      res.neg_cycle = changed;
      res.last = (k == n - 1);
      expected_nodes = {expected_nodes, res};
    end
    stored_count = 0;
  endtask

  task automatic send_edge(input logic [NODE_W-1:0] from, input logic [NODE_W-1:0] to,
                           input logic [COST_W-1:0] cost, input logic fin);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, cost, to, from};
    s_tlast <= fin;
    do @(posedge clk); while (!s_tready);
    predict_edge(from, to, cost, fin);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_nodes.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers are written back to back while the block is idle
  task automatic set_config(input logic [6:0] nc, input logic [6:0] sn);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= REG_NODE_COUNT;
    cfg_data <= nc;
    do @(posedge clk); while (!cfg_ready);
    node_count_reg = nc;
    cfg_index <= REG_START_NODE;
    cfg_data <= sn;
    do @(posedge clk); while (!cfg_ready);
    start_node_reg = sn[NODE_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  // mostly in-range endpoints, a few out of range; returns the number of edges sent
  task automatic send_random_graph(input int edge_max, output int sent);
    int n;
    int from;
    int to;
    logic [COST_W-1:0] cost;
    bit wide_costs;
    n = (node_count_reg == 0) ? 1 : ((node_count_reg > MAX_NODES) ? MAX_NODES : node_count_reg);
    sent = $urandom_range(1, edge_max);
    wide_costs = ($urandom_range(0, 2) == 0);
    for (int i = 0; i < sent; i++) begin
      from = ($urandom_range(0, 7) != 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 63);
      to = ($urandom_range(0, 7) != 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 63);
      if (wide_costs) cost = COST_W'($urandom_range(0, 16'hFFFF));
      else cost = COST_W'($urandom_range(0, 43) - 3);
      send_edge(NODE_W'(from), NODE_W'(to), cost, i == sent - 1);
    end
  endtask

  task automatic test_directed_paths();
    send_edge(6'd0, 6'd1, 16'sd5, 1'b0);
    send_edge(6'd1, 6'd2, -16'sd3, 1'b0);
    send_edge(6'd0, 6'd2, 16'sd10, 1'b0);
    send_edge(6'd2, 6'd3, 16'sd32767, 1'b0);
    send_edge(6'd3, 6'd4, 16'sd32767, 1'b0);
    send_edge(6'd4, 6'd63, -16'sd32768, 1'b0);
    send_edge(6'd63, 6'd62, 16'sd1, 1'b1);
  endtask

  task automatic test_config_extremes();
    // negative cycle plus endpoints past node_count
    set_config(7'd4, 7'd1);
    send_edge(6'd1, 6'd2, -16'sd1, 1'b0);
    send_edge(6'd5, 6'd1, 16'sd2, 1'b0);
    send_edge(6'd1, 6'd60, 16'sd2, 1'b0);
    send_edge(6'd2, 6'd1, -16'sd1, 1'b0);
    send_edge(6'd0, 6'd3, 16'sd7, 1'b1);
    // zero node count acts as one node
    set_config(7'd0, 7'd0);
    send_edge(6'd0, 6'd0, -16'sd1, 1'b1);
    set_config(7'd1, 7'd0);
    send_edge(6'd0, 6'd0, 16'sd5, 1'b1);
    // above the node limit acts as the limit
    set_config(7'd127, 7'd63);
    send_edge(6'd63, 6'd0, -16'sd32768, 1'b0);
    send_edge(6'd0, 6'd5, 16'sd100, 1'b1);
    // start node outside the graph: nothing reachable
    set_config(7'd4, 7'd10);
    send_edge(6'd0, 6'd1, 16'sd3, 1'b1);
  endtask

  task automatic test_output_stall();
    int sent;
    set_config(7'd64, 7'd0);
    rx_hold_request = 400;
    tx_max_gap = 0;
    send_random_graph(10, sent);
    send_random_graph(10, sent);
    tx_max_gap = 8;
  endtask

  task automatic test_random_graphs();
    int total;
    int sent;
    int n;
    logic [6:0] nc;
    logic [6:0] sn;
    total = 0;
    while (total < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 5))
          0: nc = 7'd0;
          1: nc = 7'd1;
          2: nc = 7'($urandom_range(2, 8));
          3: nc = 7'($urandom_range(1, 64));
          4: nc = 7'd64;
          default: nc = 7'($urandom_range(65, 127));
        endcase
        n = (nc == 0) ? 1 : ((nc > MAX_NODES) ? MAX_NODES : nc);
        sn = ($urandom_range(0, 4) != 0) ? 7'($urandom_range(0, n - 1))
                                          : 7'($urandom_range(0, 127));
        set_config(nc, sn);
      end
      tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 8;
      rx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 8;
      send_random_graph(16, sent);
      total += sent;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_paths();
    test_config_extremes();
    test_output_stall();
    test_random_graphs();
    drain_results();
    if (mismatch_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // result receiver: random stalls, plus a long hold when a test asks for one
  initial begin
    int gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (rx_hold_request > 0) begin
        gap = rx_hold_request;
        rx_hold_request = 0;
      end else begin
        gap = $urandom_range(0, rx_max_gap);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    node_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_nodes.size() == 0) begin
        report_mismatch("unexpected result node_id", m_tdata[5:0], -1);
      end else begin
        want = expected_nodes.pop_front();
        if (m_tdata[5:0] !== want.node) report_mismatch("node_id", m_tdata[5:0], want.node);
        if (m_tdata[37:6] !== want.length)
          report_mismatch("path_length", $signed(m_tdata[37:6]), want.length);
        if (m_tuser[0] !== want.reach) report_mismatch("reachable", m_tuser[0], want.reach);
        if (m_tuser[1] !== want.neg_cycle)
          report_mismatch("negative_cycle", m_tuser[1], want.neg_cycle);
        if (m_tlast !== want.last) report_mismatch("last_node", m_tlast, want.last);
      end
    end
  end

  // ends the run when no transaction of any kind completes for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/sssp_pkg.sv
rtl/single_source_shortest_paths.sv
tb/sv/single_source_shortest_paths_test.sv
